### rtl/core/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/kmwuf_pkg.sv
// constants and codes for the maze wall union-find block
package kmwuf_pkg;

    // item field widths
    localparam int COL_W  = 5;
    localparam int ROW_W  = 5;
    localparam int GRID_W = 6;

    // width of the cell index arithmetic before range checks
    localparam int CALC_W = 12;

    // rank field of one set entry
    localparam int RANK_W = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
    localparam logic [GRID_W-1:0]    GRID_RESET      = 6'd63;

    // op codes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_WALL  = 1'b1;

    // default sizes
    localparam int DEF_MAX_COLS  = 32;
    localparam int DEF_MAX_ROWS  = 32;
    localparam int DEF_MAX_CELLS = 1024;

endpackage

### rtl/core/kmwuf_ifs.sv
// channel interfaces: wall items in, results out, register writes

interface kmwuf_in_if import kmwuf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic             downward;

    modport source (output valid, output op, output cell_col, output cell_row,
                    output downward, input ready);
    modport sink   (input valid, input op, input cell_col, input cell_row,
                    input downward, output ready);
endinterface

interface kmwuf_out_if import kmwuf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              wall_removed;
    logic [GRID_W-1:0] wall_x;
    logic [GRID_W-1:0] wall_y;
    logic              status;

    modport source (output valid, output wall_removed, output wall_x, output wall_y,
                    output status, input ready);
    modport sink   (input valid, input wall_removed, input wall_x, input wall_y,
                    input status, output ready);
endinterface

interface kmwuf_cfg_if import kmwuf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

### rtl/core/kruskal_maze_wall_union_find.sv
// kruskal maze carving: disjoint-set table of maze cells in one memory
//
//  channel  | dir | payload                                   | notes
//  ---------+-----+-------------------------------------------+------------------------
//  in_ch    | in  | op, cell_col, cell_row, downward          | one wall or clear item
//  out_ch   | out | wall_removed, wall_x, wall_y, status      | one result per item
//  cfg_ch   | in  | addr (0 grid_width, 1 grid_height), wdata | always ready
//
//  a wall item walks each of its two cells to the root of its set; every walk step is one
//  read of the set memory, whose read port is registered
//  a clear item rewrites the whole set memory: one memory entry written per cycle
//  after reset the same clearing pass runs with in_ch.ready low
//  a result waiting in the output register does not stop the next item being taken;
//  a second finished result waits for out_ch.ready and holds in_ch.ready low meanwhile
module kruskal_maze_wall_union_find import kmwuf_pkg::*; #(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_CELLS = DEF_MAX_CELLS
) (
    input  logic         clk,
    input  logic         rst_n,
    kmwuf_in_if.sink     in_ch,
    kmwuf_out_if.source  out_ch,
    kmwuf_cfg_if.sink    cfg_ch
);

`include "assert_macros.svh"

    // cell index and memory word layout: {rank, parent}
    localparam int IDX_W  = $clog2(MAX_CELLS);
    localparam int WORD_W = RANK_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CELLS - 1);

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // clearing pass over the set memory
    localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for an item
    localparam logic [2:0] ST_PREP  = 3'd2;  // bounds check and cell indices
    localparam logic [2:0] ST_START = 3'd3;  // issue read of the walk start cell
    localparam logic [2:0] ST_FIND  = 3'd4;  // follow parent links to the root
    localparam logic [2:0] ST_COMP  = 3'd5;  // second walk, point path at the root
    localparam logic [2:0] ST_UNION = 3'd6;  // link the lower-rank root
    localparam logic [2:0] ST_RANK  = 3'd7;  // equal ranks: bump the new root's rank

    // state machine and pass control
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_emit_reg, clr_emit_next;
    logic             out_pend_reg, out_pend_next;  // finished result waits for out reg
    logic             pass_reg, pass_next;          // 0 first cell, 1 neighbor
    logic             out_valid_reg, out_valid_next;
    logic [GRID_W-1:0] gw_reg, gh_reg;

    // walk and item registers
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  v_reg, v_next;
    logic [IDX_W-1:0]  start_a_reg, start_a_next, start_b_reg, start_b_next;
    logic [IDX_W-1:0]  root_a_reg, root_a_next, root_b_reg, root_b_next;
    logic [RANK_W-1:0] rank_a_reg, rank_a_next, rank_b_reg, rank_b_next;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              down_reg;

    // working result and output register
    logic              removed_reg, removed_next;
    logic [GRID_W-1:0] wx_reg, wx_next, wy_reg, wy_next;
    logic              status_reg, status_next;
    logic              out_removed_reg;
    logic [GRID_W-1:0] out_wx_reg, out_wy_reg;
    logic              out_status_reg;

    // set memory
    logic [WORD_W-1:0] set_mem [MAX_CELLS];
    logic [WORD_W-1:0] rdata_reg;
    logic              rd_en, mem_we;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [IDX_W-1:0]  rd_parent;
    logic [RANK_W-1:0] rd_rank;
    logic [IDX_W-1:0]  cur_root, cur_start;
    logic [RANK_W-1:0] rank_inc;
    logic              in_acc, load_out;

    // grid geometry
    logic [GRID_W-1:0] cols_raw, rows_raw, cols, rows;
    logic [GRID_W-1:0] col1, row1, col2, row2;
    logic [CALC_W-1:0] idx1_calc, idx2_calc;
    logic              off_grid;

    assign rd_parent = rdata_reg[IDX_W-1:0];
    assign rd_rank   = rdata_reg[WORD_W-1 -: RANK_W];
    assign cur_root  = pass_reg ? root_b_reg : root_a_reg;
    assign cur_start = pass_reg ? start_b_reg : start_a_reg;
    assign rank_inc  = (rank_a_reg == RANK_MAX) ? rank_a_reg : rank_a_reg + 1'b1;

    // the working result registers hold a pending result, so no new item until it moves
    assign in_ch.ready  = (state_reg == ST_IDLE) && !out_pend_reg;
    assign in_acc       = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.wall_removed = out_removed_reg;
    assign out_ch.wall_x       = out_wx_reg;
    assign out_ch.wall_y       = out_wy_reg;
    assign out_ch.status       = out_status_reg;

    // cells sit at even grid units: (size+1)/2 cells, capped at the table shape
    assign cols_raw = GRID_W'(({1'b0, gw_reg} + 7'd1) >> 1);
    assign rows_raw = GRID_W'(({1'b0, gh_reg} + 7'd1) >> 1);
    assign cols = (32'(cols_raw) > MAX_COLS) ? GRID_W'(MAX_COLS) : cols_raw;
    assign rows = (32'(rows_raw) > MAX_ROWS) ? GRID_W'(MAX_ROWS) : rows_raw;

    assign col1 = GRID_W'(col_reg);
    assign row1 = GRID_W'(row_reg);
    assign col2 = col1 + GRID_W'(!down_reg);
    assign row2 = row1 + GRID_W'(down_reg);

    assign idx1_calc = CALC_W'(row1) * CALC_W'(cols) + CALC_W'(col1);
    assign idx2_calc = CALC_W'(row2) * CALC_W'(cols) + CALC_W'(col2);

    assign off_grid = (col1 >= cols) || (row1 >= rows) || (col2 >= cols) || (row2 >= rows)
                   || (32'(idx1_calc) >= MAX_CELLS) || (32'(idx2_calc) >= MAX_CELLS);

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_emit_next = clr_emit_reg;
        out_pend_next = out_pend_reg;
        pass_next     = pass_reg;
        cur_next      = cur_reg;
        v_next        = v_reg;
        start_a_next  = start_a_reg;
        start_b_next  = start_b_reg;
        root_a_next   = root_a_reg;
        root_b_next   = root_b_reg;
        rank_a_next   = rank_a_reg;
        rank_b_next   = rank_b_reg;
        removed_next  = removed_reg;
        wx_next       = wx_reg;
        wy_next       = wy_reg;
        status_next   = status_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        mem_we        = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = {{RANK_W{1'b0}}, clr_cnt_reg};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    clr_cnt_next  = '0;
                    out_pend_next = clr_emit_reg;
                    clr_emit_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    removed_next = 1'b0;
                    wx_next      = '0;
                    wy_next      = '0;
                    status_next  = 1'b0;
                    if (in_ch.op == OP_CLEAR)
                    begin
                        clr_cnt_next  = '0;
                        clr_emit_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                pass_next = 1'b0;
                if (off_grid)
                begin
                    status_next   = 1'b1;
                    out_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    // wall sits between the two cells on the grid
                    wx_next      = {col_reg, !down_reg};
                    wy_next      = {row_reg, down_reg};
                    start_a_next = IDX_W'(idx1_calc);
                    start_b_next = IDX_W'(idx2_calc);
                    state_next   = ST_START;
                end
            end
            ST_START:
            begin
                rd_en      = 1'b1;
                rd_addr    = cur_start;
                cur_next   = cur_start;
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if (rd_parent == cur_reg)
                begin
                    // root reached: keep it with its rank
                    if (pass_reg)
                    begin
                        root_b_next = cur_reg;
                        rank_b_next = rd_rank;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        rank_a_next = rd_rank;
                    end
                    if (cur_reg == cur_start)
                    begin
                        pass_next  = 1'b1;
                        state_next = pass_reg ? ST_UNION : ST_START;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cur_start;
                        v_next     = cur_start;
                        state_next = ST_COMP;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_parent;
                    cur_next = rd_parent;
                end
            end
            ST_COMP:
            begin
                // path compression: v keeps its rank, points straight at the root
                mem_we  = 1'b1;
                wr_addr = v_reg;
                wr_data = {rd_rank, cur_root};
                if (rd_parent == cur_root)
                begin
                    pass_next  = 1'b1;
                    state_next = pass_reg ? ST_UNION : ST_START;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = rd_parent;
                    v_next  = rd_parent;
                end
            end
            ST_UNION:
            begin
                if (root_a_reg == root_b_reg)
                begin
                    out_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    removed_next = 1'b1;
                    mem_we       = 1'b1;
                    if (rank_a_reg < rank_b_reg)
                    begin
                        wr_addr       = root_a_reg;
                        wr_data       = {rank_a_reg, root_b_reg};
                        out_pend_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        wr_addr = root_b_reg;
                        wr_data = {rank_b_reg, root_a_reg};
                        if (rank_a_reg > rank_b_reg)
                        begin
                            out_pend_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_RANK;
                        end
                    end
                end
            end
            ST_RANK:
            begin
                mem_we        = 1'b1;
                wr_addr       = root_a_reg;
                wr_data       = {rank_inc, root_a_reg};
                out_pend_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a finished result moves to the output register once it is free;
        // until then the block holds in idle with ready low
        if (out_pend_reg && (!out_valid_reg || out_ch.ready))
            out_pend_next = 1'b0;
    end

    assign load_out       = out_pend_reg && (!out_valid_reg || out_ch.ready);
    assign out_valid_next = load_out || (out_valid_reg && !out_ch.ready);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_emit_reg  <= 1'b0;
            out_pend_reg  <= 1'b0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            gw_reg        <= GRID_RESET;
            gh_reg        <= GRID_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_emit_reg  <= clr_emit_next;
            out_pend_reg  <= out_pend_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.addr)
                    REG_GRID_WIDTH:  gw_reg <= GRID_W'(cfg_ch.wdata);
                    REG_GRID_HEIGHT: gh_reg <= GRID_W'(cfg_ch.wdata);
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        v_reg       <= v_next;
        start_a_reg <= start_a_next;
        start_b_reg <= start_b_next;
        root_a_reg  <= root_a_next;
        root_b_reg  <= root_b_next;
        rank_a_reg  <= rank_a_next;
        rank_b_reg  <= rank_b_next;
        removed_reg <= removed_next;
        wx_reg      <= wx_next;
        wy_reg      <= wy_next;
        status_reg  <= status_next;
        if (in_acc)
        begin
            col_reg  <= in_ch.cell_col;
            row_reg  <= in_ch.cell_row;
            down_reg <= in_ch.downward;
        end
        if (load_out)
        begin
            out_removed_reg <= removed_reg;
            out_wx_reg      <= wx_reg;
            out_wy_reg      <= wy_reg;
            out_status_reg  <= status_reg;
        end
    end

    // set memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            set_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= set_mem[rd_addr];
    end

    // the sequencer never reads the entry it writes in the same cycle
    `ASSERT_IMPL(a_no_rw_clash, clk, rst_n, mem_we && rd_en, wr_addr != rd_addr)
    // a taken item always moves the sequencer out of idle
    `ASSERT_NEXT(a_item_starts, clk, rst_n, in_acc, state_reg != ST_IDLE)
    // linking only happens between two different roots
    `ASSERT_IMPL(a_union_roots, clk, rst_n, (state_reg == ST_UNION) && mem_we,
                 root_a_reg != root_b_reg)
    // a carved wall is never reported together with an off-grid flag
    `ASSERT_IMPL(a_removed_ok, clk, rst_n, out_valid_reg && out_removed_reg, !out_status_reg)

endmodule
